### rtl/core/bscc_pkg.sv
// Shared types and constants for the block shift coincidence counter.
`timescale 1ns / 1ps

package bscc_pkg;

    // Configuration port layout
    localparam int CFG_DW = 13;
    localparam logic [0:0] CFG_BLOCK_LEN  = 1'b0;
    localparam logic [0:0] CFG_SHIFT_SIZE = 1'b1;

    // Register reset values
    localparam logic [12:0] BLOCK_LEN_RST  = 13'd4096;
    localparam logic [11:0] SHIFT_SIZE_RST = 12'd1;

    // One result word
    typedef struct packed {
        logic [12:0] block_matches;
        logic [31:0] total_matches;
        logic [31:0] total_bytes;
        logic        final_res;
    } t_result;

endpackage

### rtl/core/bscc_fifo.sv
// Small register FIFO used for the block queue and the result queue.
`timescale 1ns / 1ps

module bscc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Pointer and occupancy update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/core/bscc_front.sv
// Front end: takes bytes, fills the current bank, closes blocks and queues them.
`timescale 1ns / 1ps

module bscc_front #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    input  logic [0:0]                i_cfg_index,
    input  logic [bscc_pkg::CFG_DW-1:0] i_cfg_data,
    output logic                      o_cfg_ready,
    // byte input
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_end_of_data,
    // block memory write port
    output logic                      o_wr_en,
    output logic [$clog2(MAX_BLOCK):0] o_wr_addr,
    output logic [7:0]                o_wr_data,
    // block descriptor queue
    output logic                      o_desc_push,
    output logic [1+$clog2(MAX_BLOCK+1)+$clog2(MAX_BLOCK)+1+32-1:0] o_desc_data,
    // bank freed by the back end
    input  logic                      i_release
);

    localparam int AW = $clog2(MAX_BLOCK);
    localparam int CW = $clog2(MAX_BLOCK + 1);

    logic [12:0]   r_block_len, n_block_len;
    logic [11:0]   r_shift, n_shift;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;
    logic [31:0]   r_bytes, n_bytes;

    logic          w_acc;
    logic          w_close;
    logic [31:0]   w_len32;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] w_fill_new;
    logic [11:0]   w_shift_new;
    logic [31:0]   w_bytes_new;

    assign o_cfg_ready = 1'b1;
    // both banks hold closed blocks: nowhere to write
    assign o_full      = (r_busy == 2'd2);
    assign w_acc       = i_push && !o_full;

    // Effective block length, clamped to 1..MAX_BLOCK
    assign w_len32 = {19'd0, r_block_len};
    always_comb begin
        if (r_block_len == 13'd0) begin
            w_eff = CW'(1);
        end else if (w_len32 > 32'(MAX_BLOCK)) begin
            w_eff = CW'(MAX_BLOCK);
        end else begin
            w_eff = CW'(w_len32);
        end
    end

    assign w_fill_new  = r_fill + CW'(1);
    assign w_close     = i_end_of_data || (w_fill_new >= w_eff);
    assign w_bytes_new = r_bytes + 32'd1;
    // sticky clamp of the shift to len-1
    assign w_shift_new = ({20'd0, r_shift} >= 32'(w_fill_new)) ?
                         12'(w_fill_new - CW'(1)) : r_shift;

    assign o_wr_en     = w_acc;
    assign o_wr_addr   = {r_bank, r_fill[AW-1:0]};
    assign o_wr_data   = i_data_byte;
    assign o_desc_push = w_acc && w_close;
    assign o_desc_data = {r_bank, w_fill_new, AW'({20'd0, w_shift_new}),
                          i_end_of_data, w_bytes_new};

    // Fill, bank, busy-bank tracking and register writes
    always_comb begin
        n_fill      = r_fill;
        n_bank      = r_bank;
        n_shift     = r_shift;
        n_bytes     = r_bytes;
        n_busy      = r_busy;
        n_block_len = r_block_len;
        if (w_acc) begin
            n_bytes = w_bytes_new;
            if (w_close) begin
                n_fill  = '0;
                n_bank  = !r_bank;
                n_shift = w_shift_new;
            end else begin
                n_fill  = w_fill_new;
            end
        end
        if (o_desc_push && !i_release) begin
            n_busy = r_busy + 2'd1;
        end else if (i_release && !o_desc_push) begin
            n_busy = r_busy - 2'd1;
        end
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bscc_pkg::CFG_BLOCK_LEN: begin
                    n_block_len = i_cfg_data[12:0];
                end
                bscc_pkg::CFG_SHIFT_SIZE: begin
                    n_shift = i_cfg_data[11:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= bscc_pkg::BLOCK_LEN_RST;
            r_shift     <= bscc_pkg::SHIFT_SIZE_RST;
            r_fill      <= '0;
            r_bank      <= 1'b0;
            r_busy      <= 2'd0;
            r_bytes     <= 32'd0;
        end else begin
            r_block_len <= n_block_len;
            r_fill      <= n_fill;
            r_bank      <= n_bank;
            r_busy      <= n_busy;
            r_bytes     <= n_bytes;
            r_shift     <= n_shift;
        end
    end

    // never more than two closed blocks in flight
    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy <= 2'd2)
        else $error("busy bank count out of range");

    // a bank is only freed when one is held
    a_release_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_release |-> (r_busy != 2'd0))
        else $error("bank released while none busy");

    // fill stays below the block length limit between bytes
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < 32'(MAX_BLOCK))
        else $error("fill count reached block limit");

endmodule

### rtl/core/bscc_back.sv
// Back end: walks a closed block in the memory and counts shifted coincidences.
`timescale 1ns / 1ps

module bscc_back #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // memory write port from the front end
    input  logic                      i_wr_en,
    input  logic [$clog2(MAX_BLOCK):0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    // block descriptor queue
    input  logic                      i_desc_empty,
    input  logic [1+$clog2(MAX_BLOCK+1)+$clog2(MAX_BLOCK)+1+32-1:0] i_desc_data,
    output logic                      o_desc_pop,
    // result queue
    input  logic                      i_res_full,
    output logic                      o_res_push,
    output bscc_pkg::t_result         o_res,
    // bank done
    output logic                      o_release
);

    localparam int AW        = $clog2(MAX_BLOCK);
    localparam int CW        = $clog2(MAX_BLOCK + 1);
    localparam int MEM_DEPTH = 2 * (2 ** AW);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    logic [7:0]    r_mem [MEM_DEPTH];
    logic [7:0]    r_rd_a, r_rd_b;

    t_state        r_state, n_state;
    logic          r_bank, n_bank;
    logic [CW-1:0] r_len, n_len;
    logic [AW-1:0] r_last_idx, n_last_idx;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_final, n_final;
    logic [31:0]   r_bytes, n_bytes;
    logic [31:0]   r_total, n_total;
    logic          r_rv;

    logic          w_rd_en;
    logic          d_bank;
    logic [CW-1:0] d_len;
    logic [AW-1:0] d_shift;
    logic          d_last;
    logic [31:0]   d_bytes;

    assign {d_bank, d_len, d_shift, d_last, d_bytes} = i_desc_data;

    // Walk sequencer: one position per cycle, each compared in the cycle after its read
    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_len      = r_len;
        n_last_idx = r_last_idx;
        n_i        = r_i;
        n_j        = r_j;
        n_final    = r_final;
        n_bytes    = r_bytes;
        n_total    = r_total;
        n_cnt      = (r_rv && (r_rd_a == r_rd_b)) ? r_cnt + CW'(1) : r_cnt;
        w_rd_en    = 1'b0;
        o_desc_pop = 1'b0;
        o_res_push = 1'b0;
        o_release  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_desc_empty && !i_res_full) begin
                    o_desc_pop = 1'b1;
                    n_bank     = d_bank;
                    n_len      = d_len;
                    n_last_idx = AW'(d_len - CW'(1));
                    n_i        = '0;
                    n_j        = d_shift;
                    n_cnt      = '0;
                    n_final    = d_last;
                    n_bytes    = d_bytes;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                w_rd_en = 1'b1;
                n_i     = r_i + AW'(1);
                n_j     = (r_j == r_last_idx) ? '0 : r_j + AW'(1);
                if (r_i == r_last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                o_res_push = 1'b1;
                o_release  = 1'b1;
                n_total    = r_total + 32'(r_cnt);
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.block_matches = 13'(r_cnt);
    assign o_res.total_matches = r_total + 32'(r_cnt);
    assign o_res.total_bytes   = r_bytes;
    assign o_res.final_res     = r_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rv    <= 1'b0;
            r_total <= 32'd0;
        end else begin
            r_state <= n_state;
            r_rv    <= w_rd_en;
            r_total <= n_total;
        end
    end

    // Walk payload, no reset
    always_ff @(posedge i_clk) begin
        r_bank     <= n_bank;
        r_len      <= n_len;
        r_last_idx <= n_last_idx;
        r_i        <= n_i;
        r_j        <= n_j;
        r_cnt      <= n_cnt;
        r_final    <= n_final;
        r_bytes    <= n_bytes;
    end

    // Two-bank block memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (w_rd_en) begin
            r_rd_a <= r_mem[{r_bank, r_i}];
            r_rd_b <= r_mem[{r_bank, r_j}];
        end
    end

    // front never writes the bank being walked
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && (r_state == ST_WALK)) |-> (i_wr_addr[AW] != r_bank))
        else $error("write into bank under walk");

    // result only pushed where the queue has room
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    // partner index stays inside the block
    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_j <= r_last_idx))
        else $error("shifted index outside block");

    // matches never exceed block length
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_cnt <= r_len))
        else $error("match count above block length");

endmodule

### rtl/core/block_shift_coincidence_counter.sv
// Top level: byte front end, block queue, coincidence back end, result queue.
// Usage:
//   Bytes enter on a queue-style port: a word is taken when push is high and
//   full is low. end_of_data marks the last byte and closes a short block.
//   Results leave on a queue-style port: the oldest result is shown while
//   empty is low and is taken when pop is high.
//   Registers (block_len, shift_size) are written over i_cfg_valid/o_cfg_ready
//   with i_cfg_index; write them only while the block is idle.
// Timing:
//   Each byte is written straight into the current bank. A closed block of len
//   bytes is walked by the back end at one position per cycle; after the walk
//   it passes a drain state, and its result is pushed from a final state. Two
//   memory banks let the next block load while the previous one is walked,
//   and full rises when both banks hold closed blocks.
// Reset:
//   Synchronous, active low; clears totals, fill, queues and restores
//   block_len = 4096 and shift_size = 1. Memory is not cleared.
// Stall:
//   When the result queue fills, the back end holds off the next block and
//   the front end stops taking bytes once both banks are taken.
`timescale 1ns / 1ps

module block_shift_coincidence_counter #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [0:0]                  i_cfg_index,
    input  logic [bscc_pkg::CFG_DW-1:0] i_cfg_data,
    // byte input
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_end_of_data,
    // results
    output logic                        empty,
    input  logic                        pop,
    output logic [12:0]                 o_block_matches,
    output logic [31:0]                 o_total_matches,
    output logic [31:0]                 o_total_bytes,
    output logic                        o_final_res
);

    localparam int AW = $clog2(MAX_BLOCK);
    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int DW = 1 + CW + AW + 1 + 32;
    localparam int RW = $bits(bscc_pkg::t_result);

    logic          w_wr_en;
    logic [AW:0]   w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_desc_push;
    logic [DW-1:0] w_desc_in;
    logic [DW-1:0] w_desc_out;
    logic          w_desc_full;
    logic          w_desc_empty;
    logic          w_desc_pop;
    logic          w_release;
    logic          w_res_push;
    logic          w_res_full;
    bscc_pkg::t_result w_res_in;
    bscc_pkg::t_result w_res_out;
    logic [RW-1:0] w_res_data;

    bscc_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_push       (push),
        .o_full       (full),
        .i_data_byte  (i_data_byte),
        .i_end_of_data(i_end_of_data),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_desc_push  (w_desc_push),
        .o_desc_data  (w_desc_in),
        .i_release    (w_release)
    );

    // closed-block queue, one slot per bank
    bscc_fifo #(.WIDTH(DW), .DEPTH(2)) u_desc_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_desc_push),
        .i_data (w_desc_in),
        .o_full (w_desc_full),
        .i_pop  (w_desc_pop),
        .o_data (w_desc_out),
        .o_empty(w_desc_empty)
    );

    bscc_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_desc_empty(w_desc_empty),
        .i_desc_data (w_desc_out),
        .o_desc_pop  (w_desc_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .o_release   (w_release)
    );

    // result queue decouples the receiver
    bscc_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_in),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_res_data),
        .o_empty(empty)
    );

    assign w_res_out       = bscc_pkg::t_result'(w_res_data);
    assign o_block_matches = w_res_out.block_matches;
    assign o_total_matches = w_res_out.total_matches;
    assign o_total_bytes   = w_res_out.total_bytes;
    assign o_final_res     = w_res_out.final_res;

    // block queue sized so a closed block always finds a slot
    a_desc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_desc_push |-> !w_desc_full)
        else $error("block queue overflow");

    // a block is taken only when present
    a_desc_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_desc_pop |-> !w_desc_empty)
        else $error("block queue underflow");

    // a bank frees only with a result
    a_release_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_release |-> w_res_push)
        else $error("bank freed without result");

endmodule
